[sv/ums_pkg.sv]
// Shared types, constants and tap table of the unsharp mask stream core.
`default_nettype none
package ums_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int TAPS           = 7;
	localparam int HB_LINES       = 10;
	localparam int PIX_W          = 24;
	localparam int ACC_W          = 20;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AMOUNT_Q8      = 2'd3;

	localparam logic [11:0] RST_IMAGE_WIDTH    = 12'd640;
	localparam logic [12:0] RST_IMAGE_HEIGHT   = 13'd480;
	localparam logic [7:0]  RST_DIFF_THRESHOLD = 8'd0;
	localparam logic [9:0]  RST_AMOUNT_Q8      = 10'd256;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	localparam logic [PIX_W-1:0] PAD_PIXEL = 24'hFFFFFF;

	typedef struct packed {
		logic accept;
		logic start;
		logic hmac;
		logic hwrite;
		logic adv;
		logic vaddr;
		logic vmac;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic ignore;
		logic pixel;
		logic has_h;
		logic col_done;
		logic tap_last;
		logic emit_ok;
		logic border;
		logic out_free;
	} sts_t;

	// Q12 Gaussian taps, symmetric around the center tap.
	function automatic logic [10:0] tap_coef(input logic [2:0] idx);
		logic [10:0] c;
		unique case (idx)
			3'd0, 3'd6: c = 11'd25;
			3'd1, 3'd5: c = 11'd250;
			3'd2, 3'd4: c = 11'd991;
			3'd3:       c = 11'd1569;
			default:    c = 11'd0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[sv/ums_ctrl.sv]
// Controller state machine that sequences one transaction through the datapath.
`default_nettype none
module ums_ctrl
	import ums_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECIDE = 8'b0000_0010,
		S_HMAC   = 8'b0000_0100,
		S_HWR    = 8'b0000_1000,
		S_ADV    = 8'b0001_0000,
		S_VADDR  = 8'b0010_0000,
		S_VMAC   = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				priority if (sts.ignore) state_d = S_IDLE;
				else if (sts.pixel && sts.has_h) state_d = S_HMAC;
				else state_d = S_ADV;
			end
			S_HMAC: begin
				if (sts.tap_last) state_d = S_HWR;
			end
			S_HWR: begin
				state_d = sts.col_done ? S_ADV : S_HMAC;
			end
			S_ADV: begin
				priority if (!sts.emit_ok) state_d = S_IDLE;
				else if (sts.border) state_d = S_EMIT;
				else state_d = S_VADDR;
			end
			S_VADDR: begin
				state_d = S_VMAC;
			end
			S_VMAC: begin
				state_d = sts.tap_last ? S_EMIT : S_VADDR;
			end
			S_EMIT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign s_tready   = (state_q == S_IDLE);
	assign cmd.accept = (state_q == S_IDLE) && s_tvalid;
	assign cmd.start  = (state_q == S_DECIDE) && !sts.ignore;
	assign cmd.hmac   = (state_q == S_HMAC);
	assign cmd.hwrite = (state_q == S_HWR);
	assign cmd.adv    = (state_q == S_ADV);
	assign cmd.vaddr  = (state_q == S_VADDR);
	assign cmd.vmac   = (state_q == S_VMAC);
	assign cmd.emit   = (state_q == S_EMIT) && sts.out_free;

endmodule
`default_nettype wire

[sv/ums_datapath.sv]
// Datapath: configuration, position counters, line stores, blur MAC, sharpening and output.
`default_nettype none
module ums_datapath
	import ums_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [PIX_W-1:0]      s_tdata,
	input  wire logic                  s_tuser,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [PIX_W-1:0]           m_tdata,
	output logic                       m_tlast
);

	localparam int WW       = $clog2(MAX_WIDTH + 1);
	localparam int HW       = $clog2(MAX_HEIGHT + 1);
	localparam int CW       = $clog2(MAX_WIDTH);
	localparam int RW       = $clog2(MAX_HEIGHT);
	localparam int VW       = HW + 1;
	localparam int TW       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int PW       = $clog2(MAX_WIDTH * MAX_HEIGHT + 3 * MAX_WIDTH + 4);
	localparam int LW       = $clog2(3 * MAX_WIDTH + 4);
	localparam int DEPTH    = 3 * MAX_WIDTH + 3;
	localparam int DAW      = $clog2(DEPTH);
	localparam int DSW      = DAW + 1;
	localparam int HB_DEPTH = HB_LINES * MAX_WIDTH;
	localparam int HAW      = $clog2(HB_DEPTH);
	localparam logic [HAW-1:0] MW_A = HAW'(MAX_WIDTH);

	// Configuration registers.
	logic [11:0] width_q;
	logic [12:0] height_q;
	logic [7:0]  thr_q;
	logic [9:0]  amt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			thr_q    <= RST_DIFF_THRESHOLD;
			amt_q    <= RST_AMOUNT_Q8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:    width_q  <= cfg_data[11:0];
				REG_IMAGE_HEIGHT:   height_q <= cfg_data[12:0];
				REG_DIFF_THRESHOLD: thr_q    <= cfg_data[7:0];
				REG_AMOUNT_Q8:      amt_q    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	logic geom_wr;
	assign geom_wr = cfg_we &&
		((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	always_comb begin
		priority if (width_q == 12'd0) w_eff = WW'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(width_q);
		priority if (height_q == 13'd0) h_eff = HW'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
		else h_eff = HW'(height_q);
	end

	// Frame size and output lag, refreshed every cycle from the registers.
	logic [TW-1:0] total_q;
	logic [LW-1:0] lag_q;
	logic [TW-1:0] w_t, h_t;
	logic [LW-1:0] w_l;

	assign w_t = TW'(w_eff);
	assign h_t = TW'(h_eff);
	assign w_l = LW'(w_eff);

	always_ff @(posedge clk) begin
		total_q <= w_t * h_t;
		lag_q   <= (w_l << 1) + w_l + LW'(3);
	end

	// Captured input transaction.
	logic             kind_q;
	logic [PIX_W-1:0] px_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= s_tuser;
			px_q   <= s_tdata;
		end
	end

	// Position counters.
	logic [CW-1:0] col_q;
	logic [3:0]    rmod_q;
	logic [PW-1:0] p_q;
	logic [TW-1:0] out_cnt_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;
	logic [3:0]    out_rmod_q;
	logic [2:0]    tap_q;
	logic [3:0]    vrow_q;
	logic [DAW-1:0] ptr_q;

	logic [WW-1:0] col_nx, out_col_nx;
	logic          col_last, out_col_last, lt_total, frame_end, border;
	logic          lt_total_out;
	logic [4:0]    vstart_sum;
	logic [3:0]    vstart;

	assign col_nx       = WW'(col_q) + WW'(1);
	assign col_last     = (col_nx == w_eff);
	assign out_col_nx   = WW'(out_col_q) + WW'(1);
	assign out_col_last = (out_col_nx == w_eff);
	assign lt_total     = (p_q < PW'(total_q));
	assign lt_total_out = (out_cnt_q < total_q);
	assign frame_end    = ((out_cnt_q + TW'(1)) == total_q);
	assign border       = (out_row_q == '0) || (HW'(out_row_q) == (h_eff - HW'(1))) ||
	                      (out_col_q == '0) || out_col_last;
	assign vstart_sum   = 5'(out_rmod_q) + 5'd7;
	assign vstart       = (vstart_sum >= 5'd10) ? 4'(vstart_sum - 5'd10) : vstart_sum[3:0];

	logic restart;
	assign restart = geom_wr || (cmd.emit && frame_end);

	// Horizontal column iteration for the current pixel.
	logic [CW-1:0] hc_q, hc_end_q;
	logic [1:0]    hd_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hc_q     <= (col_q >= CW'(3)) ? col_q - CW'(3) : '0;
			hd_q     <= (col_q >= CW'(3)) ? 2'd3 : col_q[1:0];
			hc_end_q <= col_last ? col_q : col_q - CW'(3);
		end else if (cmd.hwrite) begin
			hc_q <= hc_q + CW'(1);
			hd_q <= hd_q - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			rmod_q     <= '0;
			p_q        <= '0;
			out_cnt_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_rmod_q <= '0;
			tap_q      <= '0;
			vrow_q     <= '0;
			ptr_q      <= '0;
		end else begin
			if (cmd.start) begin
				ptr_q <= (ptr_q == DAW'(DEPTH - 1)) ? '0 : ptr_q + DAW'(1);
			end
			priority if (cmd.start || cmd.hwrite || cmd.adv) begin
				tap_q <= '0;
			end else if (cmd.hmac || cmd.vmac) begin
				tap_q <= tap_q + 3'd1;
			end
			if (cmd.adv) begin
				vrow_q <= vstart;
			end else if (cmd.vmac) begin
				vrow_q <= (vrow_q == 4'd9) ? 4'd0 : vrow_q + 4'd1;
			end
			priority if (restart) begin
				col_q      <= '0;
				rmod_q     <= '0;
				p_q        <= '0;
				out_cnt_q  <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_rmod_q <= '0;
			end else if (cmd.adv) begin
				p_q <= p_q + PW'(1);
				if (col_last) begin
					col_q  <= '0;
					rmod_q <= (rmod_q == 4'd9) ? 4'd0 : rmod_q + 4'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (cmd.emit) begin
				out_cnt_q <= out_cnt_q + TW'(1);
				if (out_col_last) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + RW'(1);
					out_rmod_q <= (out_rmod_q == 4'd9) ? 4'd0 : out_rmod_q + 4'd1;
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// Window of the newest raw pixels of the line; entry TAPS-1 is the newest.
	logic [PIX_W-1:0] win_q [TAPS];
	logic is_pixel;
	assign is_pixel = (kind_q == KIND_PIXEL) && lt_total;

	always_ff @(posedge clk) begin
		if (cmd.start && is_pixel) begin
			for (int i = 0; i < TAPS - 1; i++) begin
				win_q[i] <= (col_q == '0) ? PAD_PIXEL : win_q[i + 1];
			end
			win_q[TAPS - 1] <= px_q;
		end
	end

	// Delay line of raw pixels that aligns the original with the blur.
	logic [PIX_W-1:0] dmem [DEPTH];
	logic [PIX_W-1:0] orig_q;
	logic [DSW-1:0]   ptr_e, lag_e;
	logic [DAW-1:0]   rd_addr;

	assign ptr_e   = DSW'(ptr_q);
	assign lag_e   = DSW'(lag_q);
	assign rd_addr = (ptr_e >= lag_e) ? DAW'(ptr_e - lag_e)
	                                  : DAW'(ptr_e + DSW'(DEPTH) - lag_e);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			orig_q        <= dmem[rd_addr];
			dmem[ptr_q]   <= is_pixel ? px_q : PAD_PIXEL;
		end
	end

	// Shared seven-tap MAC, one tap at a time for all three channels.
	logic [ACC_W-1:0] acc_q [3];
	logic [PIX_W-1:0] hb_rd_q;
	logic             pad_q;
	logic [3:0]       kk;
	logic [7:0]       samp [3];
	logic [ACC_W-1:0] prod [3];
	logic [PIX_W-1:0] blur_px;

	assign kk = {1'b0, tap_q} + 4'd3 - {2'b00, hd_q};

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			if (cmd.hmac) begin
				samp[ch] = (kk > 4'd6) ? 8'hFF : win_q[kk[2:0]][8*ch +: 8];
			end else begin
				samp[ch] = pad_q ? 8'hFF : hb_rd_q[8*ch +: 8];
			end
			prod[ch] = ACC_W'(tap_coef(tap_q)) * ACC_W'(samp[ch]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hmac || cmd.vmac) begin
			for (int ch = 0; ch < 3; ch++) begin
				acc_q[ch] <= ((tap_q == 3'd0) ? '0 : acc_q[ch]) + prod[ch];
			end
		end
	end

	assign blur_px = {acc_q[2][ACC_W-1:12], acc_q[1][ACC_W-1:12], acc_q[0][ACC_W-1:12]};

	// Ring of horizontally blurred lines.
	logic [PIX_W-1:0] hmem [HB_DEPTH];
	logic [HAW-1:0]   hw_addr, hr_addr;
	logic [VW-1:0]    vrt, vlim;

	assign hw_addr = HAW'(rmod_q) * MW_A + HAW'(hc_q);
	assign hr_addr = HAW'(vrow_q) * MW_A + HAW'(out_col_q);
	assign vrt     = VW'(out_row_q) + VW'(tap_q);
	assign vlim    = VW'(h_eff) + VW'(3);

	always_ff @(posedge clk) begin
		if (cmd.hwrite) begin
			hmem[hw_addr] <= blur_px;
		end
		if (cmd.vaddr) begin
			hb_rd_q <= hmem[hr_addr];
			pad_q   <= (vrt < VW'(3)) || (vrt >= vlim);
		end
	end

	// Sharpening of one channel.
	function automatic logic [7:0] sharpen(input logic [7:0] o, input logic [7:0] b,
		input logic [7:0] thr, input logic [9:0] amt);
		logic        neg;
		logic [7:0]  mag_d;
		logic [17:0] mp;
		logic [9:0]  mag;
		logic [10:0] v;
		logic [7:0]  res;
		neg   = (b > o);
		mag_d = neg ? (b - o) : (o - b);
		mp    = 18'(mag_d) * 18'(amt);
		mag   = mp[17:8];
		v     = '0;
		if (mag_d <= thr) begin
			res = o;
		end else if (neg) begin
			res = (mag > 10'(o)) ? 8'd0 : 8'(10'(o) - mag);
		end else begin
			v   = 11'(o) + 11'(mag);
			res = (v > 11'd255) ? 8'd255 : v[7:0];
		end
		return res;
	endfunction

	logic [PIX_W-1:0] sharp_px;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sharp_px[8*ch +: 8] = sharpen(orig_q[8*ch +: 8], blur_px[8*ch +: 8], thr_q, amt_q);
		end
	end

	// Output register.
	logic             m_valid_q;
	logic [PIX_W-1:0] m_data_q;
	logic             m_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_data_q <= border ? orig_q : sharp_px;
			m_last_q <= frame_end;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	assign sts.ignore   = (kind_q == KIND_DRAIN) && lt_total;
	assign sts.pixel    = is_pixel;
	assign sts.has_h    = (col_q >= CW'(3)) || col_last;
	assign sts.col_done = (hc_q == hc_end_q);
	assign sts.tap_last = (tap_q == 3'(TAPS - 1));
	assign sts.emit_ok  = (p_q >= PW'(lag_q)) && lt_total_out;
	assign sts.border   = border;
	assign sts.out_free = !m_valid_q || m_tready;

	// A waiting result is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_valid_q || m_tready))
		else $error("result loaded over a waiting result");

	// Every blurred column that is written lies inside the line.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hwrite |-> (WW'(hc_q) < w_eff))
		else $error("horizontal blur column outside the line");

	// The vertical blur runs only for outputs that the frame still owes.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.vaddr |-> (out_cnt_q < total_q))
		else $error("vertical blur started past the frame");

endmodule
`default_nettype wire

[sv/unsharp_mask_rgb_stream_core.sv]
// Top level of the RGB888 unsharp mask stream core.
// Sharpens an RGB888 raster stream with a separable 7-tap Gaussian blur; each output
// follows its input by three lines plus three pixels, and drain transactions after the
// frame flush the rest. One transaction is handled at a time: a dropped early drain
// goes straight back to idle, any other transaction writes none to four blurred columns
// (one in the middle of a line) and, once an output is due, emits a border or an interior
// output. A single shared multiply-accumulate unit does one tap at a time for both blur
// passes. No memory is cleared after reset. The output register lets a finished result
// wait while the next transaction is taken.
`default_nettype none
module unsharp_mask_rgb_stream_core
	import ums_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [PIX_W-1:0]      s_tdata,   // in_red, in_green, in_blue
	input  wire logic                  s_tuser,   // kind
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [PIX_W-1:0]           m_tdata,   // out_red, out_green, out_blue
	output logic                       m_tlast
);

	cmd_t cmd;
	sts_t sts;

	ums_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ums_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

[tb/sv/tb_unsharp_mask_rgb_stream_core.sv]
// Self-checking testbench of the RGB888 unsharp mask stream core.
`default_nettype none
module tb_unsharp_mask_rgb_stream_core;
	import ums_pkg::*;

	localparam int MAXW           = DEF_MAX_WIDTH;
	localparam int MAXH           = DEF_MAX_HEIGHT;
	localparam int DELAY_DEPTH    = 3 * MAXW + 3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 64;
	localparam int HOLD_CYCLES    = 3000;
	localparam int PHASE_ITEMS    = 370;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata;   // in_red, in_green, in_blue
	logic                  s_tuser;   // kind
	logic                  m_tvalid;
	logic                  m_tready;
	logic [PIX_W-1:0]      m_tdata;   // out_red, out_green, out_blue
	logic                  m_tlast;

	unsharp_mask_rgb_stream_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// Predictor state: registers, stream position and the two line stores.
	int        width_reg, height_reg, threshold_reg, gain_reg;
	bit [23:0] row_pixels [TAPS];
	bit [23:0] hblur_store [HB_LINES * MAXW];
	bit [23:0] delayed_pixels [DELAY_DEPTH];
	int        delay_wr;
	int        col_pos, row_pos, out_count;
	bit        frame_done;
	bit [24:0] expected_pixels [$];

	int send_idle_pct, stall_pct;
	int items_done;
	int mismatches;
	int idle_cycles;
	int hold_req, hold_seen, hold_left;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int gauss_tap(input int i);
		case (i)
			0, 6: return 25;
			1, 5: return 250;
			2, 4: return 991;
			default: return 1569;
		endcase
	endfunction

	function automatic int clamp_dim(input int v, input int vmax);
		if (v == 0) return 1;
		return (v > vmax) ? vmax : v;
	endfunction

	function automatic bit [23:0] rand_pixel(input bit extremes);
		bit [23:0] v;
		v = 24'($urandom);
		if (extremes)
			for (int ch = 0; ch < 3; ch++)
				if ($urandom_range(2) != 0) v[8*ch +: 8] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
		return v;
	endfunction

	task automatic restart_position();
		for (int i = 0; i < TAPS; i++) row_pixels[i] = PAD_PIXEL;
		col_pos = 0;
		row_pos = 0;
		out_count = 0;
	endtask

	// Advances the predictor by one accepted transaction and queues its result.
	task automatic predict_sharpened(input bit kind, input bit [23:0] px);
		int w, h, total, lag, p, j, lo, hi, r, c, y, k, ch, sum, o, b, dif, mag, v;
		bit is_pix, last;
		bit [23:0] orig, hb, res;
		w = clamp_dim(width_reg, MAXW);
		h = clamp_dim(height_reg, MAXH);
		total = w * h;
		lag = 3 * w + 3;
		p = row_pos * w + col_pos;
		// A drain before the frame is complete is dropped.
		if (kind == KIND_DRAIN && p < total) return;
		items_done++;
		is_pix = (kind == KIND_PIXEL) && (p < total);
		orig = delayed_pixels[(delay_wr + DELAY_DEPTH - lag) % DELAY_DEPTH];
		delayed_pixels[delay_wr] = is_pix ? px : PAD_PIXEL;
		delay_wr = (delay_wr + 1) % DELAY_DEPTH;
		if (is_pix) begin
			j = col_pos;
			if (j == 0)
				for (int i = 0; i < TAPS; i++) row_pixels[i] = PAD_PIXEL;
			for (int i = 0; i < TAPS - 1; i++) row_pixels[i] = row_pixels[i + 1];
			row_pixels[TAPS - 1] = px;
			lo = (j - 3 < 0) ? 0 : j - 3;
			hi = (j == w - 1) ? j : j - 3;
			for (c = lo; c <= hi; c++) begin
				for (ch = 0; ch < 3; ch++) begin
					sum = 0;
					for (int i = 0; i < TAPS; i++) begin
						k = c + 3 + i - j;
						sum += gauss_tap(i) * ((k > 6 || k < 0) ? 255 : int'(row_pixels[k][8*ch +: 8]));
					end
					hb[8*ch +: 8] = 8'(sum >> 12);
				end
				hblur_store[(row_pos % HB_LINES) * MAXW + c] = hb;
			end
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (p >= lag && out_count < total) begin
			r = out_count / w;
			c = out_count % w;
			for (ch = 0; ch < 3; ch++) begin
				o = orig[8*ch +: 8];
				if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
					v = o;
				end else begin
					sum = 0;
					for (int i = 0; i < TAPS; i++) begin
						y = r - 3 + i;
						sum += gauss_tap(i) * ((y < 0 || y >= h) ? 255 :
							int'(hblur_store[(y % HB_LINES) * MAXW + c][8*ch +: 8]));
					end
					b = (sum >> 12) & 255;
					dif = o - b;
					v = o;
					if (dif > threshold_reg || dif < -threshold_reg) begin
						mag = (((dif < 0) ? -dif : dif) * gain_reg) >> 8;
						v = (dif < 0) ? o - mag : o + mag;
						if (v < 0) v = 0;
						if (v > 255) v = 255;
					end
				end
				res[8*ch +: 8] = 8'(v);
			end
			out_count++;
			last = (out_count == total);
			expected_pixels.push_back({last, res});
			if (last) begin
				frame_done = 1'b1;
				restart_position();
			end
		end
	endtask

	// Offers one transaction after a random gap and waits until it is taken.
	task automatic send_item(input bit kind, input bit [23:0] px);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		predict_sharpened(kind, px);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH: begin
				width_reg = value & 12'hFFF;
				restart_position();
			end
			REG_IMAGE_HEIGHT: begin
				height_reg = value & 13'h1FFF;
				restart_position();
			end
			REG_DIFF_THRESHOLD: threshold_reg = value & 8'hFF;
			default:            gain_reg = value & 10'h3FF;
		endcase
	endtask

	task automatic set_frame(input int w, input int h, input int thr, input int gain);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_DIFF_THRESHOLD, thr);
		write_reg(REG_AMOUNT_Q8, gain);
	endtask

	// Sends up to pixel_limit pixels of a frame; a complete frame is then drained,
	// with early drains and surplus pixels mixed in at noise_pct.
	task automatic run_frame(input int pixel_limit, input bit extremes, input int noise_pct);
		int total;
		total = clamp_dim(width_reg, MAXW) * clamp_dim(height_reg, MAXH);
		frame_done = 1'b0;
		for (int n = 0; n < total && n < pixel_limit; n++) begin
			if ($urandom_range(99) < noise_pct) send_item(KIND_DRAIN, rand_pixel(1'b0));
			send_item(KIND_PIXEL, rand_pixel(extremes));
		end
		if (pixel_limit < total) return;
		while (!frame_done) begin
			if ($urandom_range(99) < noise_pct) send_item(KIND_PIXEL, rand_pixel(1'b0));
			else send_item(KIND_DRAIN, rand_pixel(1'b0));
		end
	endtask

	task automatic test_directed();
		set_frame(4, 3, 0, 256);
		run_frame(12, 1'b1, 25);
		wait_idle();
		// Zero geometry behaves as a single pixel frame.
		set_frame(0, 0, 255, 1023);
		run_frame(1, 1'b1, 50);
		wait_idle();
		set_frame(3, 3, 255, 1023);
		run_frame(9, 1'b1, 0);
		wait_idle();
		set_frame(3, 3, 0, 0);
		run_frame(9, 1'b1, 0);
		wait_idle();
	endtask

	task automatic test_geometry_abort();
		set_frame(5, 4, 3, 512);
		run_frame(7, 1'b0, 10);
		wait_idle();
		// Oversized geometry saturates; the partial frame gives no output yet.
		set_frame(4095, 8191, 0, 256);
		run_frame(20, 1'b0, 10);
		wait_idle();
		set_frame(6, 5, 1, 300);
		run_frame(30, 1'b1, 5);
		wait_idle();
	endtask

	task automatic test_random_frames(input int idle_pct, input int stall, input bit pressure);
		int w, h, total, goal;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		goal = items_done + PHASE_ITEMS;
		if (pressure) hold_req++;
		while (items_done < goal) begin
			if ($urandom_range(7) == 0) begin
				w = $urandom_range(13, 40);
				h = $urandom_range(1, 3);
			end else begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 8);
			end
			set_frame(w, h,
				($urandom_range(3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12),
				$urandom_range(0, 1023));
			total = w * h;
			if ($urandom_range(9) == 0) run_frame($urandom_range(0, total - 1), 1'b0, 5);
			else run_frame(total, $urandom_range(3) == 0, 5);
			wait_idle();
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		bit [24:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output pixel %h last %b", m_tdata, m_tlast);
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata[7:0] !== want[7:0] || m_tdata[15:8] !== want[15:8] ||
						m_tdata[23:16] !== want[23:16] || m_tlast !== want[24]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pixel mismatch: expected %h last %b, got %h last %b",
							want[23:0], want[24], m_tdata, m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tuser   = KIND_PIXEL;
		s_tdata   = '0;
		m_tready  = 1'b0;
		hold_req = 0;
		hold_seen = 0;
		hold_left = 0;
		idle_cycles = 0;
		mismatches = 0;
		items_done = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		width_reg = RST_IMAGE_WIDTH;
		height_reg = RST_IMAGE_HEIGHT;
		threshold_reg = RST_DIFF_THRESHOLD;
		gain_reg = RST_AMOUNT_Q8;
		delay_wr = 0;
		frame_done = 1'b0;
		restart_position();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_geometry_abort();
		test_random_frames(0, 0, 1'b0);
		test_random_frames(63, 0, 1'b0);
		test_random_frames(0, 63, 1'b0);
		test_random_frames(25, 25, 1'b0);
		test_random_frames(0, 0, 1'b1);
		wait_idle();
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

[unsharp_mask_rgb_stream_core.f]
sv/ums_pkg.sv
sv/ums_ctrl.sv
sv/ums_datapath.sv
sv/unsharp_mask_rgb_stream_core.sv
tb/sv/tb_unsharp_mask_rgb_stream_core.sv
